FILE: hdl/iudrc_pkg.sv
// Shared types and constants for the IPv4/UDP/DHCP receive check.
// Used by the top level and by its port checker; depends on nothing.

package iudrc_pkg;

    // Receive buffer limit, in bytes
    localparam int BUFFER_BYTES_DEF = 576;
    localparam int COUNT_W          = 10;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_CLIENT_PORT  = 2'd0;
    localparam t_cfg_index CFG_MAGIC_COOKIE = 2'd1;

    localparam logic [15:0] CLIENT_PORT_RST  = 16'd68;
    localparam logic [31:0] MAGIC_COOKIE_RST = 32'h6382_5363;

    // Byte offsets inside the datagram
    localparam logic [COUNT_W-1:0] OFS_VER_IHL  = 10'd0;
    localparam logic [COUNT_W-1:0] OFS_TLEN_LO  = 10'd3;
    localparam logic [COUNT_W-1:0] OFS_PROTO    = 10'd9;
    localparam logic [COUNT_W-1:0] OFS_HCSUM_HI = 10'd10;
    localparam logic [COUNT_W-1:0] OFS_HCSUM_LO = 10'd11;
    localparam logic [COUNT_W-1:0] IP_HDR_BYTES = 10'd20;
    localparam logic [COUNT_W-1:0] OFS_DPORT_LO = 10'd23;
    localparam logic [COUNT_W-1:0] OFS_ULEN_LO  = 10'd25;
    localparam logic [COUNT_W-1:0] OFS_UCSUM_HI = 10'd26;
    localparam logic [COUNT_W-1:0] OFS_UCSUM_LO = 10'd27;
    localparam logic [COUNT_W-1:0] HDR_BYTES    = 10'd28;
    localparam logic [COUNT_W-1:0] COOKIE_POS   = 10'd264;
    localparam logic [COUNT_W-1:0] COOKIE_END   = 10'd268;

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [3:0] IP_VERSION = 4'd4;
    localparam logic [3:0] IP_IHL     = 4'd5;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_VALID     = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_TRUNCATED = 3'd2,
        VERDICT_BOGUS     = 3'd3,
        VERDICT_IP_CSUM   = 3'd4,
        VERDICT_UDP_CSUM  = 3'd5,
        VERDICT_MAGIC     = 3'd6
    } t_verdict;

    // Per-datagram state captured on the last byte
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [19:0]        header_sum;
        logic [25:0]        udp_sum;
        logic [15:0]        total_length;
        logic [7:0]         version_ihl;
        logic [7:0]         protocol_num;
        logic [15:0]        header_check;
        logic [15:0]        dest_port;
        logic [15:0]        udp_length;
        logic [15:0]        udp_check;
        logic [31:0]        cookie_seen;
    } t_snap;

    // Partly evaluated checks, one stage before the verdict
    typedef struct packed {
        logic        too_short;
        logic        truncated;
        logic        bogus;
        logic        udp_on;
        logic        bad_magic;
        logic [16:0] hdr_fold;
        logic [16:0] udp_fold;
        logic [15:0] header_check;
        logic [15:0] udp_check;
        logic [9:0]  payload_length;
    } t_judge;

endpackage

FILE: hdl/ipv4_udp_dhcp_receive_check.sv
// IPv4/UDP/DHCP receive check: byte stream in, one verdict per datagram out.
// Depends on iudrc_pkg.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[2:0] verdict, [12:3] payload_length
//  cfg       in   i_cfg_we (no wait)           i_cfg_index, i_cfg_data[31:0]
//
// One byte is taken per cycle while the skid is empty; the sums and header
// latches update in the cycle after a byte is registered. The verdict shows on m_axis
// after the byte register, state update, first fold, second fold and priority.
// Reset is synchronous and clears all datagram state and restores the registers.
// A stalled result holds in the output register; a skid register on the input
// keeps the byte side moving until a fourth result would be blocked.

module ipv4_udp_dhcp_receive_check
    import iudrc_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration writes
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    // Byte stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tlast,   // last_byte
    // Verdicts
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [2:0] verdict, [12:3] payload_length
);

    localparam logic [COUNT_W-1:0] BUF_LIMIT = COUNT_W'(BUFFER_BYTES);

    // Configuration registers
    logic [15:0] r_client_port;
    logic [31:0] r_magic_cookie;

    // Input skid and byte register
    logic        r_sk_valid, r_sk_last;
    logic [7:0]  r_sk_data;
    logic        r_b_valid, r_b_last;
    logic [7:0]  r_b_data;

    // Datagram state
    t_snap       r_st, n_st;
    logic [7:0]  r_high_byte_hold;

    // Result pipeline
    logic        r_1_valid, r_2_valid, r_o_valid;
    t_snap       r_1;
    t_judge      r_2, n_2;
    t_verdict    r_o_verdict, n_o_verdict;
    logic [9:0]  r_o_payload, n_o_payload;

    logic        hold_o, hold_2, hold_1, hold_b;
    logic        s_acc, b_fire;

    // Byte-step signals
    logic [COUNT_W-1:0] idx;
    logic               take;
    logic [15:0]        word, pair;
    logic               hdr_add, udp_add;

    // Stage 2 and output stage signals
    logic [26:0] udp_total;
    logic [16:0] hdr_f2, udp_f2;
    logic [15:0] hdr_calc, udp_calc;

    // Stall chain: a stage holds only if it carries a result that cannot move
    assign hold_o = r_o_valid & ~m_axis_tready;
    assign hold_2 = r_2_valid & hold_o;
    assign hold_1 = r_1_valid & hold_2;
    assign hold_b = r_b_valid & r_b_last & hold_1;
    assign b_fire = r_b_valid & ~hold_b;

    assign s_axis_tready = ~r_sk_valid;
    assign s_acc         = s_axis_tvalid & s_axis_tready;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port  <= CLIENT_PORT_RST;
            r_magic_cookie <= MAGIC_COOKIE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLIENT_PORT:  r_client_port  <= i_cfg_data[15:0];
                CFG_MAGIC_COOKIE: r_magic_cookie <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input skid and byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
            r_b_valid  <= 1'b0;
        end else if (!hold_b) begin
            if (r_sk_valid) begin
                r_b_valid  <= 1'b1;
                r_b_data   <= r_sk_data;
                r_b_last   <= r_sk_last;
                r_sk_valid <= 1'b0;
            end else begin
                r_b_valid <= s_acc;
                r_b_data  <= s_axis_tdata;
                r_b_last  <= s_axis_tlast;
            end
        end else if (s_acc) begin
            r_sk_valid <= 1'b1;
            r_sk_data  <= s_axis_tdata;
            r_sk_last  <= s_axis_tlast;
        end
    end

    // Per-byte update of counts, sums and header latches
    assign idx  = r_st.byte_count;
    assign take = (idx < BUF_LIMIT);
    assign word = idx[0] ? {8'd0, r_b_data} : {r_b_data, 8'd0};
    assign pair = {r_high_byte_hold, r_b_data};
    assign hdr_add = (idx < IP_HDR_BYTES) && (idx != OFS_HCSUM_HI) && (idx != OFS_HCSUM_LO);
    assign udp_add = (idx >= OFS_PROTO) && (idx != OFS_HCSUM_HI) && (idx != OFS_HCSUM_LO)
                  && (idx != OFS_UCSUM_HI) && (idx != OFS_UCSUM_LO)
                  && ({6'd0, idx} < r_st.total_length);

    always_comb begin
        n_st = r_st;
        if (take) begin
            n_st.byte_count = idx + 10'd1;
            if (hdr_add) n_st.header_sum = 20'(r_st.header_sum + {4'd0, word});
            if (udp_add) n_st.udp_sum    = 26'(r_st.udp_sum + {10'd0, word});
            unique case (idx)
                OFS_VER_IHL:  n_st.version_ihl  = r_b_data;
                OFS_TLEN_LO:  n_st.total_length = pair;
                OFS_PROTO:    n_st.protocol_num = r_b_data;
                OFS_HCSUM_LO: n_st.header_check = pair;
                OFS_DPORT_LO: n_st.dest_port    = pair;
                OFS_ULEN_LO:  n_st.udp_length   = pair;
                OFS_UCSUM_LO: n_st.udp_check    = pair;
                default: ;
            endcase
            if (idx >= COOKIE_POS && idx < COOKIE_END)
                n_st.cookie_seen = {r_st.cookie_seen[23:0], r_b_data};
        end
    end

    // Advance state; clear it after the last byte of a datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st             <= '0;
            r_high_byte_hold <= 8'd0;
        end else if (b_fire) begin
            if (r_b_last) begin
                r_st             <= '0;
                r_high_byte_hold <= 8'd0;
            end else begin
                r_st <= n_st;
                if (take) r_high_byte_hold <= r_b_data;
            end
        end
    end

    // Capture the final state of a datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_valid <= 1'b0;
        end else if (!hold_1) begin
            r_1_valid <= b_fire & r_b_last;
            r_1       <= n_st;
        end
    end

    // Header checks and first fold of both sums
    always_comb begin
        udp_total = {1'b0, r_1.udp_sum};
        if (r_1.total_length > 16'd2) udp_total = 27'(udp_total + {11'd0, r_1.udp_length & 16'hFF00});
        if (r_1.total_length > 16'd3) udp_total = 27'(udp_total + {11'd0, r_1.udp_length & 16'h00FF});

        n_2.too_short = (r_1.byte_count < HDR_BYTES);
        n_2.truncated = ({6'd0, r_1.byte_count} < r_1.total_length);
        n_2.bogus     = (r_1.protocol_num != PROTO_UDP)
                     || (r_1.version_ihl[7:4] != IP_VERSION)
                     || (r_1.version_ihl[3:0] != IP_IHL)
                     || (r_1.dest_port != r_client_port)
                     || (r_1.udp_length != 16'(r_1.total_length - 16'd20));
        n_2.udp_on    = (r_1.udp_check != 16'd0);
        n_2.bad_magic = (r_1.total_length < {6'd0, COOKIE_END})
                     || (r_1.cookie_seen != r_magic_cookie);
        n_2.hdr_fold  = {1'b0, r_1.header_sum[15:0]} + {13'd0, r_1.header_sum[19:16]};
        n_2.udp_fold  = {1'b0, udp_total[15:0]} + {6'd0, udp_total[26:16]};
        n_2.header_check   = r_1.header_check;
        n_2.udp_check      = r_1.udp_check;
        n_2.payload_length = 10'(r_1.total_length - {6'd0, HDR_BYTES});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_2_valid <= 1'b0;
        end else if (!hold_2) begin
            r_2_valid <= r_1_valid;
            r_2       <= n_2;
        end
    end

    // Second fold, checksum compare and verdict priority
    always_comb begin
        hdr_f2   = {1'b0, r_2.hdr_fold[15:0]} + {16'd0, r_2.hdr_fold[16]};
        udp_f2   = {1'b0, r_2.udp_fold[15:0]} + {16'd0, r_2.udp_fold[16]};
        hdr_calc = ~hdr_f2[15:0];
        udp_calc = ~udp_f2[15:0];
        if (r_2.too_short)                             n_o_verdict = VERDICT_SHORT;
        else if (r_2.truncated)                        n_o_verdict = VERDICT_TRUNCATED;
        else if (r_2.bogus)                            n_o_verdict = VERDICT_BOGUS;
        else if (hdr_calc != r_2.header_check)         n_o_verdict = VERDICT_IP_CSUM;
        else if (r_2.udp_on && udp_calc != r_2.udp_check) n_o_verdict = VERDICT_UDP_CSUM;
        else if (r_2.bad_magic)                        n_o_verdict = VERDICT_MAGIC;
        else                                           n_o_verdict = VERDICT_VALID;
        n_o_payload = (n_o_verdict == VERDICT_VALID) ? r_2.payload_length : 10'd0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!hold_o) begin
            r_o_valid   <= r_2_valid;
            r_o_verdict <= n_o_verdict;
            r_o_payload <= n_o_payload;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'd0, r_o_payload, r_o_verdict};

endmodule

FILE: hdl/iudrc_checker.sv
// Port-level checker for the IPv4/UDP/DHCP receive check, with its bind.
// Depends on iudrc_pkg and on the top level ipv4_udp_dhcp_receive_check.

module iudrc_checker
    import iudrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Datagrams whose last byte was transferred but whose verdict was not
    logic [2:0] r_pending;
    logic       last_acc, out_acc;

    assign last_acc = s_axis_tvalid & s_axis_tready & s_axis_tlast;
    assign out_acc  = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= 3'(r_pending + {2'd0, last_acc} - {2'd0, out_acc});
        end
    end

    // No verdict right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid right after reset");

    // A stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled verdict changed");

    // Every verdict belongs to a datagram already received in full
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 3'd0)
        else $error("verdict without a finished datagram");

    // The byte side stalls only behind a waiting verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_pending != 3'd0)
        else $error("input stalled with no verdict pending");

    // Payload length is reported only for a good datagram
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != VERDICT_VALID |-> m_axis_tdata[12:3] == 10'd0)
        else $error("payload length on a rejected datagram");

endmodule

bind ipv4_udp_dhcp_receive_check iudrc_checker u_iudrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
